[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent assertions of the table constraint block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTAC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("btac: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define BTAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("btac: next-cycle property failed");

`endif

[src/btac_pkg.sv]
// ----------------------------------------------------------------------------
// btac_pkg
// Types, field positions and helpers shared by the table constraint block.
// ----------------------------------------------------------------------------
`default_nettype none

package btac_pkg;

    localparam int DOM_MAX_DEF = 64;
    localparam int DOM_W       = 64;
    localparam int IDX_W       = 6;
    localparam int SIZE_W      = 7;
    localparam int CNT_W       = 32;
    localparam int CMD_W       = 2;
    localparam int STAT_W      = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int ADD_N_W     = 13;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_CHECK  = 2'd1,
        CMD_FILTER = 2'd2
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_WIPEOUT  = 2'd1,
        ST_ENTAILED = 2'd2,
        ST_REJECTED = 2'd3
    } status_t;

    // Input transfer layout.
    localparam int IN_CMD_LSB = 0;
    localparam int IN_IX_LSB  = 2;
    localparam int IN_IY_LSB  = 8;
    localparam int IN_AX_BIT  = 14;
    localparam int IN_AY_BIT  = 15;
    localparam int IN_DX_LSB  = 16;
    localparam int IN_DY_LSB  = 80;
    localparam int IN_W       = 144;

    // Result transfer layout.
    localparam int OUT_PX_LSB  = 0;
    localparam int OUT_PY_LSB  = 64;
    localparam int OUT_ST_LSB  = 128;
    localparam int OUT_AL_BIT  = 130;
    localparam int OUT_CNT_LSB = 131;
    localparam int OUT_USED    = 163;
    localparam int OUT_W       = 168;

    function automatic logic [DOM_W-1:0] low_mask(input logic [SIZE_W-1:0] n);
        logic [DOM_W-1:0] m;
        if (n >= SIZE_W'(DOM_W)) begin
            m = '1;
        end else begin
            m = (DOM_W'(1) << n[IDX_W-1:0]) - DOM_W'(1);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

[src/btac_rows.sv]
// ----------------------------------------------------------------------------
// btac_rows
// One bit-matrix store with a row valid flag, one write and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module btac_rows #(
    parameter int DEPTH = btac_pkg::DOM_MAX_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  wire logic [btac_pkg::DOM_W-1:0]  wr_data,
    input  wire logic                        rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]    rd_addr,
    output logic      [btac_pkg::DOM_W-1:0]  rd_data
);

    logic [btac_pkg::DOM_W-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0]           valid_reg;
    logic [btac_pkg::DOM_W-1:0] rd_data_reg;

    // A row that was never written reads as empty.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= valid_reg[rd_addr] ? mem_reg[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[src/binary_table_arc_consistency.sv]
// ----------------------------------------------------------------------------
// binary_table_arc_consistency
// Binary table constraint with row-serial arc-consistency filtering.
// ----------------------------------------------------------------------------
// Items arrive on the s_ stream: add a tuple, check a pair or filter a pair of
// domains. Every item gives exactly one result on the m_ stream. The sizes of
// the two domains are written through the write port; the user must write them
// only while the block is idle, which the block itself does not enforce. The
// table is held twice, by x rows and by y rows, in two stores with one read and
// one write port each, which one row sequencer walks one row per cycle. An add
// walks its rows: one row for a single pair, size rows for a wildcard. A check
// reads one row. A rejected add or check, or an unknown command, goes straight
// to the result. A filter walks size_x rows and then size_y rows, as
// each direction reads every row of its store in turn; a singleton domain
// needs only one direction.
// s_tready is high only while the sequencer is idle; one item is in work at
// a time. The result waits in an output register, so the next item can be
// taken while the receiver stalls; that item then holds at its final step
// until the earlier result has been transferred.
// Reset empties the table at once, clears the tuple count and sets both
// sizes to 64. It is synchronous and active low.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module binary_table_arc_consistency #(
    parameter int DOM_MAX = btac_pkg::DOM_MAX_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [btac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [btac_pkg::SIZE_W-1:0]     cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // cmd, index_x, index_y, any_x, any_y, domain_x, domain_y
    input  wire logic [btac_pkg::IN_W-1:0]       s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // pruned_x, pruned_y, status, allowed, tuple_count, zero fill
    output logic      [btac_pkg::OUT_W-1:0]      m_tdata
);

    localparam int AW     = $clog2(DOM_MAX);
    localparam int DOM_W  = btac_pkg::DOM_W;
    localparam int IDX_W  = btac_pkg::IDX_W;
    localparam int SIZE_W = btac_pkg::SIZE_W;
    localparam int CNT_W  = btac_pkg::CNT_W;
    localparam int N_W    = btac_pkg::ADD_N_W;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_ADD      = 8'b0000_0010,
        S_CHECK    = 8'b0000_0100,
        S_CLASSIFY = 8'b0000_1000,
        S_SCAN_X   = 8'b0001_0000,
        S_MID      = 8'b0010_0000,
        S_SCAN_Y   = 8'b0100_0000,
        S_FINISH   = 8'b1000_0000
    } state_t;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] r;
        if (s == '0) begin
            r = SIZE_W'(1);
        end else if (s > SIZE_W'(DOM_MAX)) begin
            r = SIZE_W'(DOM_MAX);
        end else begin
            r = s;
        end
        return r;
    endfunction

    state_t state_reg, state_next;
    logic [SIZE_W-1:0] size_x_reg, size_y_reg;
    btac_pkg::cmd_t cmd_reg, cmd_next;
    logic [IDX_W-1:0] ix_reg, ix_next, iy_reg, iy_next;
    logic ax_reg, ax_next, ay_reg, ay_next;
    logic [DOM_W-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [DOM_W-1:0] mx_reg, mx_next, my_reg, my_next;
    logic [SIZE_W-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic [N_W-1:0] add_n_reg, add_n_next;
    btac_pkg::status_t status_reg, status_next;
    logic calc_reg, calc_next;
    logic single_x_reg, single_x_next, single_y_reg, single_y_next;
    logic [SIZE_W-1:0] k_reg, k_next;
    logic pvx_reg, pvx_next, pvy_reg, pvy_next;
    logic [AW-1:0] pax_reg, pax_next, pay_reg, pay_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic [btac_pkg::OUT_W-1:0] m_tdata_reg, m_tdata_next;

    logic memx_wr_en, memy_wr_en, memx_rd_en, memy_rd_en;
    logic [AW-1:0] memx_rd_addr, memy_rd_addr;
    logic [DOM_W-1:0] memx_wr_data, memy_wr_data, rdx, rdy;

    // Input fields.
    logic [btac_pkg::CMD_W-1:0] in_cmd;
    logic [IDX_W-1:0] in_ix, in_iy;
    logic in_ax, in_ay;
    logic [DOM_W-1:0] in_dx, in_dy;

    assign in_cmd = s_tdata[btac_pkg::IN_CMD_LSB +: btac_pkg::CMD_W];
    assign in_ix  = s_tdata[btac_pkg::IN_IX_LSB +: IDX_W];
    assign in_iy  = s_tdata[btac_pkg::IN_IY_LSB +: IDX_W];
    assign in_ax  = s_tdata[btac_pkg::IN_AX_BIT];
    assign in_ay  = s_tdata[btac_pkg::IN_AY_BIT];
    assign in_dx  = s_tdata[btac_pkg::IN_DX_LSB +: DOM_W];
    assign in_dy  = s_tdata[btac_pkg::IN_DY_LSB +: DOM_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= btac_pkg::SIZE_RESET;
            size_y_reg <= btac_pkg::SIZE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                btac_pkg::CFG_SIZE_X: size_x_reg <= cfg_wdata;
                btac_pkg::CFG_SIZE_Y: size_y_reg <= cfg_wdata;
            endcase
        end
    end

    // Sizes, masks and range checks for an arriving item.
    logic [SIZE_W-1:0] sx_eff, sy_eff;
    logic [DOM_W-1:0] mx_eff, my_eff;
    logic add_reject, chk_reject;
    logic [N_W-1:0] in_add_n;

    always_comb begin
        sx_eff = eff_size(size_x_reg);
        sy_eff = eff_size(size_y_reg);
        mx_eff = btac_pkg::low_mask(sx_eff);
        my_eff = btac_pkg::low_mask(sy_eff);
        chk_reject = (SIZE_W'(in_ix) >= sx_eff) || (SIZE_W'(in_iy) >= sy_eff);
        add_reject = (!in_ax && (SIZE_W'(in_ix) >= sx_eff))
                  || (!in_ay && (SIZE_W'(in_iy) >= sy_eff));
        if (in_ax && in_ay) begin
            in_add_n = N_W'(N_W'(sx_eff) * N_W'(sy_eff));
        end else if (in_ax) begin
            in_add_n = N_W'(sx_eff);
        end else if (in_ay) begin
            in_add_n = N_W'(sy_eff);
        end else begin
            in_add_n = N_W'(1);
        end
    end

    // Shared row unit: one row against one operand mask.
    logic [DOM_W-1:0] row_sel, opd_sel, hit;
    logic [AW-1:0] row_addr;
    logic row_present;

    always_comb begin
        if (state_reg == S_SCAN_Y) begin
            row_sel  = rdy;
            opd_sel  = dx_reg;
            row_addr = pay_reg;
            row_present = dy_reg[IDX_W'(pay_reg)];
        end else begin
            row_sel  = rdx;
            opd_sel  = dy_reg;
            row_addr = pax_reg;
            row_present = dx_reg[IDX_W'(pax_reg)];
        end
        hit = row_sel & opd_sel;
    end

    // Memory write side: rows read in the previous cycle come back merged.
    assign memx_wr_en   = pvx_reg && (cmd_reg == btac_pkg::CMD_ADD);
    assign memy_wr_en   = pvy_reg && (cmd_reg == btac_pkg::CMD_ADD);
    assign memx_wr_data = rdx | (ay_reg ? my_reg : (DOM_W'(1) << iy_reg));
    assign memy_wr_data = rdy | (ax_reg ? mx_reg : (DOM_W'(1) << ix_reg));

    logic [SIZE_W-1:0] len_x, len_y, len_max;
    logic x_act, y_act, add_issue, scan_issue;
    logic empty_x, empty_y, sgl_x, sgl_y;
    logic [CNT_W:0] count_sum;
    logic out_free;
    btac_pkg::status_t fin_status;
    logic fin_allowed;
    logic [DOM_W-1:0] fin_px, fin_py;

    always_comb begin
        len_x   = ax_reg ? sx_reg : SIZE_W'(1);
        len_y   = ay_reg ? sy_reg : SIZE_W'(1);
        len_max = (len_x > len_y) ? len_x : len_y;
        x_act   = ax_reg ? (k_reg < sx_reg) : (k_reg == '0);
        y_act   = ay_reg ? (k_reg < sy_reg) : (k_reg == '0);
        add_issue = k_reg < len_max;
        scan_issue = (state_reg == S_SCAN_Y) ? (k_reg < sy_reg) : (k_reg < sx_reg);
        empty_x = dx_reg == '0;
        empty_y = dy_reg == '0;
        sgl_x   = !empty_x && ((dx_reg & (dx_reg - DOM_W'(1))) == '0);
        sgl_y   = !empty_y && ((dy_reg & (dy_reg - DOM_W'(1))) == '0);
        count_sum = {1'b0, count_reg} + (CNT_W + 1)'(add_n_reg);
        out_free  = !m_tvalid_reg || m_tready;

        if (!calc_reg) begin
            fin_status = status_reg;
        end else if (single_x_reg) begin
            fin_status = empty_y ? btac_pkg::ST_WIPEOUT : btac_pkg::ST_ENTAILED;
        end else if (single_y_reg) begin
            fin_status = empty_x ? btac_pkg::ST_WIPEOUT : btac_pkg::ST_ENTAILED;
        end else begin
            fin_status = empty_y ? btac_pkg::ST_WIPEOUT : btac_pkg::ST_OK;
        end
        fin_allowed = (cmd_reg == btac_pkg::CMD_CHECK) && (status_reg == btac_pkg::ST_OK)
                   && rdx[iy_reg];
        fin_px = (cmd_reg == btac_pkg::CMD_FILTER) ? dx_reg : '0;
        fin_py = (cmd_reg == btac_pkg::CMD_FILTER) ? dy_reg : '0;
    end

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        ix_next       = ix_reg;
        iy_next       = iy_reg;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        mx_next       = mx_reg;
        my_next       = my_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        add_n_next    = add_n_reg;
        status_next   = status_reg;
        calc_next     = calc_reg;
        single_x_next = single_x_reg;
        single_y_next = single_y_reg;
        k_next        = k_reg;
        pvx_next      = 1'b0;
        pvy_next      = 1'b0;
        pax_next      = pax_reg;
        pay_next      = pay_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        memx_rd_en    = 1'b0;
        memy_rd_en    = 1'b0;
        memx_rd_addr  = k_reg[AW-1:0];
        memy_rd_addr  = k_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next      = btac_pkg::cmd_t'(in_cmd);
                    ix_next       = in_ix;
                    iy_next       = in_iy;
                    ax_next       = in_ax;
                    ay_next       = in_ay;
                    dx_next       = in_dx & mx_eff;
                    dy_next       = in_dy & my_eff;
                    mx_next       = mx_eff;
                    my_next       = my_eff;
                    sx_next       = sx_eff;
                    sy_next       = sy_eff;
                    add_n_next    = in_add_n;
                    status_next   = btac_pkg::ST_OK;
                    calc_next     = 1'b0;
                    single_x_next = 1'b0;
                    single_y_next = 1'b0;
                    k_next        = '0;
                    unique case (in_cmd)
                        btac_pkg::CMD_ADD: begin
                            if (add_reject) begin
                                status_next = btac_pkg::ST_REJECTED;
                                state_next  = S_FINISH;
                            end else begin
                                state_next = S_ADD;
                            end
                        end
                        btac_pkg::CMD_CHECK: begin
                            if (chk_reject) begin
                                status_next = btac_pkg::ST_REJECTED;
                                state_next  = S_FINISH;
                            end else begin
                                state_next = S_CHECK;
                            end
                        end
                        btac_pkg::CMD_FILTER: state_next = S_CLASSIFY;
                        default:              state_next = S_FINISH;
                    endcase
                end
            end
            S_ADD: begin
                memx_rd_addr = ax_reg ? k_reg[AW-1:0] : ix_reg[AW-1:0];
                memy_rd_addr = ay_reg ? k_reg[AW-1:0] : iy_reg[AW-1:0];
                if (add_issue) begin
                    memx_rd_en = x_act;
                    memy_rd_en = y_act;
                    pvx_next   = x_act;
                    pvy_next   = y_act;
                    pax_next   = memx_rd_addr;
                    pay_next   = memy_rd_addr;
                    k_next     = k_reg + SIZE_W'(1);
                end else begin
                    count_next = count_sum[CNT_W] ? '1 : count_sum[CNT_W-1:0];
                    state_next = S_FINISH;
                end
            end
            S_CHECK: begin
                memx_rd_en   = 1'b1;
                memx_rd_addr = ix_reg[AW-1:0];
                state_next   = S_FINISH;
            end
            S_CLASSIFY: begin
                priority if (empty_x || empty_y) begin
                    status_next = btac_pkg::ST_WIPEOUT;
                    state_next  = S_FINISH;
                end else if (sgl_x) begin
                    single_x_next = 1'b1;
                    calc_next     = 1'b1;
                    state_next    = S_SCAN_X;
                end else if (sgl_y) begin
                    single_y_next = 1'b1;
                    calc_next     = 1'b1;
                    state_next    = S_SCAN_Y;
                end else begin
                    calc_next  = 1'b1;
                    state_next = S_SCAN_X;
                end
            end
            S_SCAN_X: begin
                if (pvx_reg && row_present) begin
                    if (single_x_reg) begin
                        dy_next = hit;
                    end else if (hit == '0) begin
                        dx_next[IDX_W'(row_addr)] = 1'b0;
                    end
                end
                if (scan_issue) begin
                    memx_rd_en = 1'b1;
                    pvx_next   = 1'b1;
                    pax_next   = k_reg[AW-1:0];
                    k_next     = k_reg + SIZE_W'(1);
                end else begin
                    state_next = single_x_reg ? S_FINISH : S_MID;
                end
            end
            S_MID: begin
                k_next = '0;
                if (empty_x) begin
                    status_next = btac_pkg::ST_WIPEOUT;
                    calc_next   = 1'b0;
                    state_next  = S_FINISH;
                end else begin
                    state_next = S_SCAN_Y;
                end
            end
            S_SCAN_Y: begin
                if (pvy_reg && row_present) begin
                    if (single_y_reg) begin
                        dx_next = hit;
                    end else if (hit == '0) begin
                        dy_next[IDX_W'(row_addr)] = 1'b0;
                    end
                end
                if (scan_issue) begin
                    memy_rd_en = 1'b1;
                    pvy_next   = 1'b1;
                    pay_next   = k_reg[AW-1:0];
                    k_next     = k_reg + SIZE_W'(1);
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[btac_pkg::OUT_PX_LSB +: DOM_W] = fin_px;
                    m_tdata_next[btac_pkg::OUT_PY_LSB +: DOM_W] = fin_py;
                    m_tdata_next[btac_pkg::OUT_ST_LSB +: btac_pkg::STAT_W] = fin_status;
                    m_tdata_next[btac_pkg::OUT_AL_BIT] = fin_allowed;
                    m_tdata_next[btac_pkg::OUT_CNT_LSB +: CNT_W] = count_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            pvx_reg      <= 1'b0;
            pvy_reg      <= 1'b0;
            k_reg        <= '0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            pvx_reg      <= pvx_next;
            pvy_reg      <= pvy_next;
            k_reg        <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        ix_reg       <= ix_next;
        iy_reg       <= iy_next;
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        mx_reg       <= mx_next;
        my_reg       <= my_next;
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        add_n_reg    <= add_n_next;
        status_reg   <= status_next;
        calc_reg     <= calc_next;
        single_x_reg <= single_x_next;
        single_y_reg <= single_y_next;
        pax_reg      <= pax_next;
        pay_reg      <= pay_next;
        m_tdata_reg  <= m_tdata_next;
    end

    btac_rows #(
        .DEPTH (DOM_MAX)
    ) u_rows_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (memx_wr_en),
        .wr_addr (pax_reg),
        .wr_data (memx_wr_data),
        .rd_en   (memx_rd_en),
        .rd_addr (memx_rd_addr),
        .rd_data (rdx)
    );

    btac_rows #(
        .DEPTH (DOM_MAX)
    ) u_rows_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (memy_wr_en),
        .wr_addr (pay_reg),
        .wr_data (memy_wr_data),
        .rd_en   (memy_rd_en),
        .rd_addr (memy_rd_addr),
        .rd_data (rdy)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `BTAC_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `BTAC_ASSERT_SAME(a_write_only_in_add, aclk, aresetn, memx_wr_en || memy_wr_en, state_reg == S_ADD)
    `BTAC_ASSERT_NEXT(a_count_steady, aclk, aresetn, state_reg != S_ADD, count_reg == $past(count_reg))
    `BTAC_ASSERT_SAME(a_scan_in_range, aclk, aresetn, (state_reg == S_SCAN_X) && pvx_reg, SIZE_W'(pax_reg) < sx_reg)
    `BTAC_ASSERT_NEXT(a_hold_while_stalled, aclk, aresetn, (state_reg == S_FINISH) && m_tvalid && !m_tready, state_reg == S_FINISH)

endmodule

`default_nettype wire
